>>> hw/rtl/bcse_pkg.sv
// Shared types, constants and character helpers for the C string escaper.
// No dependencies; every other file of the escaper takes names from here.
package bcse_pkg;

    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int LEN_W      = 12;
    localparam int FILL_W     = 13;
    localparam int OUT_CNT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IDX_W      = 4;   // index of a character within one word group

    localparam logic [LEN_W-1:0] LINE_LEN_RST = 12'd100;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_ESC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN   = 2'd1;

    // characters
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;

    localparam logic [IDX_W-1:0] WRAP_LEN = 4'd4;

    typedef enum logic [1:0] {
        K_LIT  = 2'd0,
        K_PAIR = 2'd1,
        K_OCT  = 2'd2
    } t_kind;

    // one classified byte, as it travels from front to back
    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            data;
        logic [7:0]            pair_ch;
        logic                  wrap;
        logic [OUT_CNT_W-1:0]  count;
    } t_desc;

    function automatic logic [2:0] seg_len(t_kind k);
        logic [2:0] len;
        case (k)
            K_LIT:   len = 3'd1;
            K_PAIR:  len = 3'd2;
            default: len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [IDX_W-1:0] total_len(t_desc d);
        return {1'b0, seg_len(d.kind)} + (d.wrap ? WRAP_LEN : 4'd0);
    endfunction

    function automatic logic [7:0] char_at(t_desc d, logic [IDX_W-1:0] k);
        logic [2:0]       seg;
        logic [IDX_W-1:0] w;
        logic [7:0]       ch;
        seg = seg_len(d.kind);
        w   = k - {1'b0, seg};
        if (k < {1'b0, seg}) begin
            case (d.kind)
                K_LIT: begin
                    ch = d.data;
                end
                K_PAIR: begin
                    ch = (k == 4'd0) ? CH_BSL : d.pair_ch;
                end
                default: begin
                    case (k[1:0])
                        2'd0:    ch = CH_BSL;
                        2'd1:    ch = CH_ZERO + {6'd0, d.data[7:6]};
                        2'd2:    ch = CH_ZERO + {5'd0, d.data[5:3]};
                        default: ch = CH_ZERO + {5'd0, d.data[2:0]};
                    endcase
                end
            endcase
        end else begin
            case (w[1:0])
                2'd0:    ch = CH_QUOTE;
                2'd1:    ch = CH_NL;
                2'd2:    ch = CH_TAB;
                default: ch = CH_QUOTE;
            endcase
        end
        return ch;
    endfunction

endpackage

>>> hw/rtl/bcse_front.sv
// Front end: configuration registers, byte classification, line fill and byte count.
// Depends on bcse_pkg.
module bcse_front #(
    parameter int COUNT_BITS = bcse_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bcse_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bcse_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_accept,
    input  logic [7:0]                        i_data_byte,
    output bcse_pkg::t_desc                   o_desc
);

    logic                             r_always_esc;
    logic [bcse_pkg::LEN_W-1:0]       r_line_len;
    logic [bcse_pkg::FILL_W-1:0]      r_fill;
    logic [bcse_pkg::FILL_W-1:0]      n_fill;
    logic [COUNT_BITS-1:0]            r_count;
    logic [COUNT_BITS-1:0]            n_count;
    bcse_pkg::t_kind                  kind;
    logic [7:0]                       pair_ch;
    logic                             printable;
    logic                             wrap;

    always_comb begin
        printable = (i_data_byte >= bcse_pkg::PRINT_LO) && (i_data_byte <= bcse_pkg::PRINT_HI)
                 && (i_data_byte != bcse_pkg::CH_QUOTE) && (i_data_byte != bcse_pkg::CH_BSL)
                 && (i_data_byte != bcse_pkg::CH_QMARK) && (i_data_byte != bcse_pkg::CH_COLON)
                 && (i_data_byte != bcse_pkg::CH_PCT);
        pair_ch = i_data_byte;
        if (r_always_esc) begin
            kind = bcse_pkg::K_OCT;
        end else if (printable) begin
            kind = bcse_pkg::K_LIT;
        end else if (i_data_byte == bcse_pkg::CH_CR) begin
            kind    = bcse_pkg::K_PAIR;
            pair_ch = bcse_pkg::CH_LOW_R;
        end else if (i_data_byte == bcse_pkg::CH_NL) begin
            kind    = bcse_pkg::K_PAIR;
            pair_ch = bcse_pkg::CH_LOW_N;
        end else if (i_data_byte == bcse_pkg::CH_TAB) begin
            kind    = bcse_pkg::K_PAIR;
            pair_ch = bcse_pkg::CH_LOW_T;
        end else if (i_data_byte == bcse_pkg::CH_QUOTE || i_data_byte == bcse_pkg::CH_BSL) begin
            kind = bcse_pkg::K_PAIR;
        end else begin
            kind = bcse_pkg::K_OCT;
        end
    end

    // fill after this byte's own characters; wrap when it reaches the line length
    always_comb begin
        n_fill  = r_fill + {{(bcse_pkg::FILL_W-3){1'b0}}, bcse_pkg::seg_len(kind)};
        wrap    = n_fill >= {1'b0, r_line_len};
        n_count = r_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    end

    always_comb begin
        o_desc.kind    = kind;
        o_desc.data    = i_data_byte;
        o_desc.pair_ch = pair_ch;
        o_desc.wrap    = wrap;
        o_desc.count   = bcse_pkg::OUT_CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_always_esc <= 1'b0;
            r_line_len   <= bcse_pkg::LINE_LEN_RST;
            r_fill       <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == bcse_pkg::REG_ALWAYS_ESC) begin
                r_always_esc <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_idx == bcse_pkg::REG_LINE_LEN) begin
                r_line_len <= i_cfg_data[bcse_pkg::LEN_W-1:0];
            end
            if (i_accept) begin
                r_fill  <= wrap ? '0 : n_fill;
                r_count <= n_count;
            end
        end
    end

endmodule

>>> hw/rtl/bcse_queue.sv
// Short descriptor queue between front and back end.
// Depends on bcse_pkg.
module bcse_queue #(
    parameter int DEPTH = bcse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  bcse_pkg::t_desc  i_wr_desc,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_valid,
    output bcse_pkg::t_desc  o_rd_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcse_pkg::t_desc    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               wr_en;
    logic               rd_en;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_rd_desc = r_mem[r_rd_ptr];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/bcse_back.sv
// Back end: walks each descriptor to the output, one char a cycle unless stalled.
// Depends on bcse_pkg.
module bcse_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_desc_valid,
    input  bcse_pkg::t_desc                    i_desc,
    output logic                               o_desc_done,
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         o_out_char,
    output logic                               o_last,
    output logic [bcse_pkg::OUT_CNT_W-1:0]     o_bytes_so_far
);

    logic                            r_out_valid;
    logic [7:0]                      r_out_char;
    logic                            r_out_last;
    logic [bcse_pkg::OUT_CNT_W-1:0]  r_out_count;
    logic [bcse_pkg::IDX_W-1:0]      r_idx;
    logic                            advance;
    logic                            emit;
    logic                            is_last;

    assign advance        = !r_out_valid || pop;
    assign emit           = advance && i_desc_valid;
    assign is_last        = (r_idx == bcse_pkg::total_len(i_desc) - 4'd1);
    assign o_desc_done    = emit && is_last;
    assign empty          = !r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_last         = r_out_last;
    assign o_bytes_so_far = r_out_count;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char  <= bcse_pkg::char_at(i_desc, r_idx);
            r_out_last  <= is_last;
            r_out_count <= i_desc.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= i_desc_valid;
            end
            if (emit) begin
                r_idx <= is_last ? '0 : r_idx + bcse_pkg::IDX_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/byte_to_c_string_escaper_core.sv
// Top level of the byte to C string-literal escaper.
// Depends on bcse_pkg, bcse_front, bcse_queue and bcse_back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  input   | in        | push / full          | i_data_byte
//  result  | out       | empty / pop          | o_out_char, o_last, o_bytes_so_far
//  config  | in        | i_cfg_we (no wait)   | i_cfg_idx, i_cfg_data
//
// Each byte yields 1 to 8 characters: 1 (plain), 2 (short escape) or 4 (octal),
// plus 4 more when the line wraps. The back end emits one character a cycle while
// the result side is popped or empty; the front takes one byte a cycle while the
// descriptor queue (QUEUE_DEPTH entries) has room.
// Reset is synchronous, active low; it empties queue and output and restores
// always_escape to 0 and line_length to 100. With the back end idle, a byte's first
// word passes through the descriptor queue and then the output register to the result ports.
// A low pop only stalls the back end; the front keeps filling until the queue is full.
module byte_to_c_string_escaper_core #(
    parameter int COUNT_BITS  = bcse_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = bcse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [bcse_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bcse_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input bytes
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_data_byte,
    // result characters
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         o_out_char,
    output logic                               o_last,
    output logic [bcse_pkg::OUT_CNT_W-1:0]     o_bytes_so_far
);

    bcse_pkg::t_desc  front_desc;
    bcse_pkg::t_desc  head_desc;
    logic             accept;
    logic             head_valid;
    logic             head_done;

    // take a byte whenever the queue has a free slot
    assign accept = push && !full;

    // classify, count and decide the wrap at the moment of acceptance
    bcse_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_desc      (front_desc)
    );

    // hold classified bytes so front and back stall on their own
    bcse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_desc (front_desc),
        .o_full    (full),
        .i_rd      (head_done),
        .o_valid   (head_valid),
        .o_rd_desc (head_desc)
    );

    // expand the head descriptor into characters; drop it after its final word
    bcse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc_valid   (head_valid),
        .i_desc         (head_desc),
        .o_desc_done    (head_done),
        .empty          (empty),
        .pop            (pop),
        .o_out_char     (o_out_char),
        .o_last         (o_last),
        .o_bytes_so_far (o_bytes_so_far)
    );

endmodule

>>> hw/rtl/bcse_checker.sv
// Port-level checks for the escaper core, attached by bind.
// Depends on bcse_pkg and byte_to_c_string_escaper_core.
module bcse_port_checks (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               empty,
    input  logic                               pop,
    input  logic [7:0]                         o_out_char,
    input  logic                               o_last,
    input  logic [bcse_pkg::OUT_CNT_W-1:0]     o_bytes_so_far
);

    // nothing left to show straight after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // a stalled word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_char) && $stable(o_last)
                           && $stable(o_bytes_so_far))
        else $error("stalled result word changed");

    // words of one byte share its count
    a_group_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_last |=> empty || o_bytes_so_far == $past(o_bytes_so_far))
        else $error("byte count changed inside one byte's words");

    // a tab that is not final belongs to a wrap and is followed by its closing quote
    a_wrap_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_last && o_out_char == bcse_pkg::CH_TAB
        |=> empty || (o_out_char == bcse_pkg::CH_QUOTE && o_last))
        else $error("wrap sequence broken after tab");

endmodule

bind byte_to_c_string_escaper_core bcse_port_checks u_bcse_port_checks (.*);
